// ===== rtl/lsbd_pkg.sv =====
// Shared types and constants for the LSB stego image deframer.
package lsbd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_VALUE  = 2'd2;

    localparam logic [9:0]  HEADER_BYTES_RST = 10'd54;
    localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
    localparam logic [63:0] MAGIC_VALUE_RST  = 64'd10787;

    localparam logic [3:0] MAGIC_MAX = 4'd8;
    localparam logic [5:0] CHAR_BITS = 6'd8;
    localparam logic [5:0] WORD_BITS = 6'd32;

    localparam logic [2:0] KIND_EXTLEN  = 3'd0;
    localparam logic [2:0] KIND_EXTCHAR = 3'd1;
    localparam logic [2:0] KIND_PAYLEN  = 3'd2;
    localparam logic [2:0] KIND_PAYBYTE = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_EXTCHAR = 3'd3,
        PH_PAYLEN  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6
    } lsbd_phase_t;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       start_req;
    } lsbd_in_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic               last;
    } lsbd_out_t;

    typedef struct packed {
        logic [9:0]  header_bytes;
        logic [3:0]  magic_length;
        logic [63:0] magic_value;
    } lsbd_cfg_t;

    typedef struct packed {
        lsbd_phase_t phase;
        logic [9:0]  header_count;
        logic [4:0]  bit_count;
        logic [31:0] bit_shift;
        logic [3:0]  magic_index;
        logic [31:0] remaining_count;
    } lsbd_state_t;

    localparam lsbd_state_t STATE_CLEAR = '{
        phase:           PH_HEADER,
        header_count:    10'd0,
        bit_count:       5'd0,
        bit_shift:       32'd0,
        magic_index:     4'd0,
        remaining_count: 32'd0
    };

endpackage

// ===== rtl/lsb_stego_bmp_deframer_core.sv =====
// Top level of the LSB stego image deframer: input stage, parse state and result register.
// A byte is captured in the input register and parsed by the combinational step logic;
// its result, if any, is written to the result register that drives out_data.
// Throughput: one image byte per cycle, set by the single-pass parse logic between
// the input register and the result register; a waiting result stalls the input stage.
// Reset: parse state returns to header skip with all counters and the bit shifter
// cleared, registers return to 54 header bytes, 2 magic characters, magic 10787.
module lsb_stego_bmp_deframer_core
    import lsbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lsbd_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lsbd_out_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    lsbd_cfg_t   cfg;
    lsbd_state_t state_reg;
    lsbd_state_t state_next;
    lsbd_in_t    in_item_reg;
    logic        in_valid_reg;
    lsbd_out_t   out_item_reg;
    logic        out_valid_reg;
    logic        emit;
    lsbd_out_t   result;
    logic        fire;

    lsbd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsbd_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    // Parse the held request once the result slot is free or being drained.
    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (fire && emit)
        begin
            out_item_reg <= result;
        end
    end

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("held input request lost while stalled");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.kind == KIND_ERROR |-> out_item_reg.last)
        else $error("magic error result without last");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && state_reg.phase == PH_DONE && !in_item_reg.start_req |=> !out_valid_reg)
        else $error("result produced after end of image");

    a_magic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.magic_index <= MAGIC_MAX)
        else $error("magic index ran past eight characters");

endmodule

// ===== rtl/lsbd_cfg_regs.sv =====
// Configuration register file: header length, magic length and magic characters.
module lsbd_cfg_regs
    import lsbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    output lsbd_cfg_t              cfg
);

    lsbd_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_bytes <= HEADER_BYTES_RST;
            cfg_reg.magic_length <= MAGIC_LENGTH_RST;
            cfg_reg.magic_value  <= MAGIC_VALUE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER_BYTES: cfg_reg.header_bytes <= cfg_data[9:0];
                CFG_MAGIC_LENGTH: cfg_reg.magic_length <= cfg_data[3:0];
                CFG_MAGIC_VALUE:  cfg_reg.magic_value  <= cfg_data;
                default:          ; // drop writes past the register list
            endcase
        end
    end

endmodule

// ===== rtl/lsbd_step.sv =====
// Per-byte parse logic: next parse state and the result for one image byte.
module lsbd_step
    import lsbd_pkg::*;
(
    input  lsbd_cfg_t   cfg,
    input  lsbd_state_t state,
    input  lsbd_in_t    item,
    output lsbd_state_t state_next,
    output logic        emit,
    output lsbd_out_t   result
);

    always_comb
    begin
        lsbd_state_t s;
        lsbd_phase_t ph;
        logic        go;
        logic [3:0]  magic_eff;
        logic [31:0] shift_n;
        logic [5:0]  cnt_n;
        logic [5:0]  need;
        logic [7:0]  want;
        logic [3:0]  mi_n;
        logic [31:0] rc_n;
        logic        positive;

        s          = item.start_req ? STATE_CLEAR : state;
        state_next = s;
        emit       = 1'b0;
        result     = '0;
        go         = 1'b1;
        ph         = s.phase;

        magic_eff = (cfg.magic_length > MAGIC_MAX) ? MAGIC_MAX : cfg.magic_length;
        shift_n   = {s.bit_shift[30:0], item.image_byte[0]};
        cnt_n     = {1'b0, s.bit_count} + 6'd1;
        want      = cfg.magic_value[{s.magic_index[2:0], 3'b000} +: 8];
        mi_n      = s.magic_index + 4'd1;
        rc_n      = s.remaining_count - 32'd1;
        positive  = (shift_n != 32'd0) && !shift_n[31];

        if (ph == PH_HEADER)
        begin
            if (s.header_count < cfg.header_bytes)
            begin
                state_next.header_count = s.header_count + 10'd1;
                go = 1'b0;
            end
            else
            begin
                ph = PH_MAGIC;
            end
        end
        if (ph == PH_MAGIC && s.magic_index >= magic_eff)
        begin
            ph = PH_EXTLEN;
        end

        need = (ph == PH_EXTLEN || ph == PH_PAYLEN) ? WORD_BITS : CHAR_BITS;

        if (go)
        begin
            state_next.phase = ph;
        end

        if (go && ph != PH_DONE)
        begin
            state_next.bit_shift = shift_n;
            if (cnt_n < need)
            begin
                state_next.bit_count = cnt_n[4:0];
            end
            else
            begin
                state_next.bit_count = 5'd0;
                case (ph)
                    PH_MAGIC:
                    begin
                        if (shift_n[7:0] != want)
                        begin
                            state_next.phase = PH_DONE;
                            emit         = 1'b1;
                            result.kind  = KIND_ERROR;
                            result.value = '0;
                            result.last  = 1'b1;
                        end
                        else
                        begin
                            state_next.magic_index = mi_n;
                            if (mi_n >= magic_eff)
                            begin
                                state_next.phase = PH_EXTLEN;
                            end
                        end
                    end
                    PH_EXTLEN:
                    begin
                        if (positive)
                        begin
                            state_next.remaining_count = shift_n;
                            state_next.phase           = PH_EXTCHAR;
                        end
                        else
                        begin
                            state_next.remaining_count = 32'd0;
                            state_next.phase           = PH_PAYLEN;
                        end
                        emit         = 1'b1;
                        result.kind  = KIND_EXTLEN;
                        result.value = shift_n;
                        result.last  = 1'b0;
                    end
                    PH_EXTCHAR:
                    begin
                        state_next.remaining_count = rc_n;
                        if (rc_n == 32'd0)
                        begin
                            state_next.phase = PH_PAYLEN;
                        end
                        emit         = 1'b1;
                        result.kind  = KIND_EXTCHAR;
                        result.value = {24'd0, shift_n[7:0]};
                        result.last  = 1'b0;
                    end
                    PH_PAYLEN:
                    begin
                        if (positive)
                        begin
                            state_next.remaining_count = shift_n;
                            state_next.phase           = PH_PAYLOAD;
                        end
                        else
                        begin
                            state_next.remaining_count = 32'd0;
                            state_next.phase           = PH_DONE;
                        end
                        emit         = 1'b1;
                        result.kind  = KIND_PAYLEN;
                        result.value = shift_n;
                        result.last  = !positive;
                    end
                    PH_PAYLOAD:
                    begin
                        state_next.remaining_count = rc_n;
                        if (rc_n == 32'd0)
                        begin
                            state_next.phase = PH_DONE;
                        end
                        emit         = 1'b1;
                        result.kind  = KIND_PAYBYTE;
                        result.value = {24'd0, shift_n[7:0]};
                        result.last  = (rc_n == 32'd0);
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule
